// ===== hdl/sfdc_pkg.sv =====
`default_nettype none
package sfdc_pkg;

  // Frame layout
  localparam int unsigned FrameBytes  = 20;   // payload bytes per frame, 18..32
  localparam int unsigned RecordBytes = 18;   // payload bytes that feed the record
  localparam int unsigned RecordWords = 14;
  localparam int unsigned SrcWords    = RecordBytes / 2;
  localparam int unsigned NumOffsets  = 5;
  localparam int unsigned CntW        = 5;
  localparam int unsigned IdxW        = 4;

  localparam logic [7:0] SyncFirst  = 8'h55;
  localparam logic [7:0] SyncSecond = 8'hA5;

  localparam logic [CntW-1:0] FrameLast = CntW'(FrameBytes - 1);
  localparam logic [CntW-1:0] StoreLim  = CntW'(RecordBytes);
  localparam logic [IdxW-1:0] LastIdx   = IdxW'(RecordWords - 1);

  // Register indexes
  typedef enum logic [2:0] {
    REG_HAND_MODE = 3'd0,
    REG_OFFSET_A  = 3'd1,
    REG_OFFSET_B  = 3'd2,
    REG_OFFSET_C  = 3'd3,
    REG_OFFSET_D  = 3'd4,
    REG_OFFSET_E  = 3'd5
  } reg_idx_e;

  // Deframer phases
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SEEN,
    PH_CAPTURE,
    PH_LOAD,
    PH_EMIT
  } phase_e;

  // Controls shared by every word cell
  typedef struct packed {
    logic load;
    logic shift;
  } wcell_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/sensor_frame_deframe_calibrate.sv =====
// Input: one byte per cycle while hunting for sync or capturing payload.
// Frame end: the 14-slot output chain is loaded in PH_LOAD, then 14 words leave one
// per cycle from slot 0 (longer under back-pressure); no byte is taken meanwhile.
// Reset (async, active low): hunting, offsets and hand mode zero, output chain empty.
`default_nettype none
module sensor_frame_deframe_calibrate (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // byte input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // word output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata,   // [15:0] word_value, [19:16] word_index
  output logic             m_axis_tlast    // last_word
);

  localparam int unsigned NB = sfdc_pkg::RecordBytes;
  localparam int unsigned NW = sfdc_pkg::RecordWords;
  localparam int unsigned NO = sfdc_pkg::NumOffsets;
  localparam int unsigned IW = sfdc_pkg::IdxW;
  localparam int unsigned CW = sfdc_pkg::CntW;

  // Configuration registers
  logic              hand_mode_q;
  logic [NO-1:0][15:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hand_mode_q <= 1'b0;
      offset_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sfdc_pkg::REG_HAND_MODE: hand_mode_q <= cfg_data_i[0];
        sfdc_pkg::REG_OFFSET_A:  offset_q[0] <= cfg_data_i;
        sfdc_pkg::REG_OFFSET_B:  offset_q[1] <= cfg_data_i;
        sfdc_pkg::REG_OFFSET_C:  offset_q[2] <= cfg_data_i;
        sfdc_pkg::REG_OFFSET_D:  offset_q[3] <= cfg_data_i;
        sfdc_pkg::REG_OFFSET_E:  offset_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control state
  sfdc_pkg::phase_e phase_q, phase_d;
  logic [CW-1:0]    count_q, count_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic             in_xfer, out_xfer, store_en;
  sfdc_pkg::wcell_ctrl_t wctrl;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sfdc_pkg::PH_HUNT;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // Next phase, byte counter, slot counter
  always_comb begin
    phase_d       = phase_q;
    count_d       = count_q;
    idx_d         = idx_q;
    s_axis_tready = 1'b0;
    store_en      = 1'b0;
    wctrl.load    = 1'b0;
    wctrl.shift   = out_xfer;
    case (phase_q)
      sfdc_pkg::PH_HUNT: begin
        s_axis_tready = 1'b1;
        if (in_xfer && s_axis_tdata == sfdc_pkg::SyncFirst) begin
          count_d = '0;
          phase_d = sfdc_pkg::PH_SEEN;
        end
      end
      sfdc_pkg::PH_SEEN: begin
        s_axis_tready = 1'b1;
        if (in_xfer) begin
          phase_d = (s_axis_tdata == sfdc_pkg::SyncSecond) ? sfdc_pkg::PH_CAPTURE
                                                           : sfdc_pkg::PH_HUNT;
        end
      end
      sfdc_pkg::PH_CAPTURE: begin
        s_axis_tready = 1'b1;
        if (in_xfer) begin
          // bytes past the record part are counted only
          store_en = (count_q < sfdc_pkg::StoreLim);
          if (count_q == sfdc_pkg::FrameLast) begin
            count_d = '0;
            phase_d = sfdc_pkg::PH_LOAD;
          end else begin
            count_d = count_q + CW'(1);
          end
        end
      end
      sfdc_pkg::PH_LOAD: begin
        wctrl.load = 1'b1;
        idx_d      = '0;
        phase_d    = sfdc_pkg::PH_EMIT;
      end
      sfdc_pkg::PH_EMIT: begin
        if (out_xfer) begin
          if (idx_q == sfdc_pkg::LastIdx) begin
            idx_d   = '0;
            phase_d = sfdc_pkg::PH_HUNT;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end
      default: phase_d = sfdc_pkg::PH_HUNT;
    endcase
  end

  // Capture chain: new byte enters at the top, byte k ends in cell k
  logic [NB-1:0][7:0] pb;

  for (genvar i = 0; i < NB; i++) begin : g_byte
    logic [7:0] nb;
    if (i == NB - 1) begin : g_top
      assign nb = s_axis_tdata;
    end else begin : g_mid
      assign nb = pb[i+1];
    end
    sfdc_byte_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(store_en),
      .byte_i (nb),
      .byte_o (pb[i])
    );
  end

  // Little-endian source words
  logic [sfdc_pkg::SrcWords-1:0][15:0] sw;
  for (genvar k = 0; k < sfdc_pkg::SrcWords; k++) begin : g_sw
    assign sw[k] = {pb[2*k+1], pb[2*k]};
  end

  // Five calibration subtractors, shared by both hand modes
  logic [NO-1:0][15:0] cal;
  for (genvar j = 0; j < NO; j++) begin : g_cal
    assign cal[j] = (hand_mode_q ? sw[8-j] : sw[4+j]) - offset_q[j];
  end

  // Record slot values
  logic [NW-1:0][15:0] rec;
  for (genvar k = 0; k < NW; k++) begin : g_rec
    if (k < 4) begin : g_pass
      assign rec[k] = sw[k];
    end else if (k < 9) begin : g_low
      assign rec[k] = hand_mode_q ? 16'h0000 : cal[k-4];
    end else begin : g_high
      assign rec[k] = hand_mode_q ? cal[k-9] : 16'h0000;
    end
  end

  // Output chain, slot 0 drives the port
  logic [NW-1:0][15:0] wv;
  logic [NW-1:0]       wvld;

  for (genvar k = 0; k < NW; k++) begin : g_word
    logic [15:0] nv;
    logic        nvld;
    if (k == NW - 1) begin : g_top
      assign nv   = 16'h0000;
      assign nvld = 1'b0;
    end else begin : g_mid
      assign nv   = wv[k+1];
      assign nvld = wvld[k+1];
    end
    sfdc_word_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (wctrl),
      .load_value_i(rec[k]),
      .next_value_i(nv),
      .next_valid_i(nvld),
      .value_o     (wv[k]),
      .valid_o     (wvld[k])
    );
  end

  assign m_axis_tvalid = wvld[0];
  assign m_axis_tdata  = {4'h0, idx_q, wv[0]};
  assign m_axis_tlast  = (idx_q == sfdc_pkg::LastIdx);

  // Words leave only while emitting
  a_out_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> phase_q == sfdc_pkg::PH_EMIT)
    else $error("word offered outside emit phase");

  // Input and output never both open
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("byte accepted while record pending");

  // Load fills slot 0
  a_load_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == sfdc_pkg::PH_LOAD |=> m_axis_tvalid && idx_q == '0)
    else $error("output chain empty after load");

  // Chain drains exactly with the last slot
  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && m_axis_tlast |=> !m_axis_tvalid && phase_q == sfdc_pkg::PH_HUNT)
    else $error("output chain not empty after last word");

endmodule
`default_nettype wire

// ===== hdl/sfdc_byte_cell.sv =====
`default_nettype none
// One payload byte of the capture chain; takes its neighbor's byte on shift.
module sfdc_byte_cell (
  input  wire logic       clk_i,
  input  wire logic       shift_i,
  input  wire logic [7:0] byte_i,
  output logic      [7:0] byte_o
);

  logic [7:0] byte_q, byte_d;

  // hold unless the chain advances
  always_comb begin
    byte_d = shift_i ? byte_i : byte_q;
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule
`default_nettype wire

// ===== hdl/sfdc_word_cell.sv =====
`default_nettype none
// One slot of the output chain: parallel load at frame end, shift toward slot 0.
module sfdc_word_cell (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire sfdc_pkg::wcell_ctrl_t ctrl_i,
  input  wire logic [15:0]          load_value_i,
  input  wire logic [15:0]          next_value_i,
  input  wire logic                 next_valid_i,
  output logic      [15:0]          value_o,
  output logic                      valid_o
);

  logic [15:0] value_q, value_d;
  logic        valid_q, valid_d;

  // load wins over shift
  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.load) begin
      value_d = load_value_i;
      valid_d = 1'b1;
    end else if (ctrl_i.shift) begin
      value_d = next_value_i;
      valid_d = next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule
`default_nettype wire

// ===== test/tb_sensor_frame_deframe_calibrate.sv =====
`default_nettype none
module tb_sensor_frame_deframe_calibrate;
  timeunit 1ns;
  timeprecision 1ps;

  import sfdc_pkg::*;

  localparam int unsigned IdlePct      = 31;    // percent of cycles a side idles
  localparam int unsigned HoldCycles   = 300;   // long receiver hold-off
  localparam int unsigned SettleCycles = 24;    // frame end to last word, plus margin
  localparam int unsigned StallLimit   = 2000;  // cycles with no transfer at all
  localparam int unsigned ItemTarget   = 410;

  // Indexes past the last register; the block must ignore them
  localparam logic [2:0] RegBeyondLo = 3'd6;
  localparam logic [2:0] RegBeyondHi = 3'd7;

  typedef struct packed {
    logic [15:0]     value;
    logic [IdxW-1:0] slot;
    logic            last;
  } word_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_index_i   = '0;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  sensor_frame_deframe_calibrate dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Byte stream waiting to be offered, and the words it is due to produce
  logic [7:0] rx_bytes_q[$];
  word_t      words_due_q[$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken  = 0;
  int unsigned err_count    = 0;
  int unsigned phase_num    = 0;
  bit          steady       = 1'b0;   // no idling on either side

  // Predicted deframer state and register copies
  phase_e      rx_phase   = PH_HUNT;
  logic [4:0]  rx_count   = '0;
  logic [7:0]  frame_buf [32];
  logic        hand_mode  = 1'b0;
  logic [15:0] offsets [NumOffsets] = '{default: '0};

  task automatic flag_error(input string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    err_count++;
  endtask

  // Build the 14-word record from the captured payload
  task automatic push_record();
    logic [15:0] w [RecordWords];
    word_t       rec;
    for (int k = 0; k < RecordWords; k++)
      w[k] = (k < SrcWords) ? {frame_buf[2*k+1], frame_buf[2*k]} : 16'h0000;
    if (!hand_mode) begin
      for (int k = 0; k < NumOffsets; k++)
        w[4+k] = w[4+k] - offsets[k];
    end else begin
      for (int k = 0; k < NumOffsets; k++)
        w[9+k] = w[8-k] - offsets[k];
      for (int k = 4; k < 9; k++)
        w[k] = 16'h0000;
    end
    for (int k = 0; k < RecordWords; k++) begin
      rec.value = w[k];
      rec.slot  = IdxW'(k);
      rec.last  = (k == RecordWords - 1);
      words_due_q.push_back(rec);
    end
  endtask

  // Advance the predicted sync/capture state by one accepted byte
  task automatic take_byte(input logic [7:0] b);
    case (rx_phase)
      PH_HUNT: begin
        if (b == SyncFirst) begin
          rx_count = '0;
          rx_phase = PH_SEEN;
        end
      end
      PH_SEEN: rx_phase = (b == SyncSecond) ? PH_CAPTURE : PH_HUNT;
      default: begin
        frame_buf[rx_count] = b;
        rx_count = rx_count + 5'd1;
        if (rx_count >= FrameBytes || rx_count == 0) begin
          rx_count = '0;
          rx_phase = PH_HUNT;
          push_record();
        end
      end
    endcase
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      REG_HAND_MODE: hand_mode = data[0];
      REG_OFFSET_A, REG_OFFSET_B, REG_OFFSET_C, REG_OFFSET_D, REG_OFFSET_E:
        offsets[idx - REG_OFFSET_A] = data;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    rx_bytes_q.push_back(b);
    bytes_queued++;
  endtask

  // Payload bytes lean toward the extremes and the sync codes
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    if (r < 27) return SyncFirst;
    if (r < 34) return SyncSecond;
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] pick_offset();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return 16'h0000;
    if (r < 50) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic queue_frame(input int unsigned len);
    queue_byte(SyncFirst);
    queue_byte(SyncSecond);
    repeat (len) queue_byte(pick_byte());
  endtask

  // Mostly clean frames, with broken syncs, cut frames and line noise mixed in
  task automatic queue_random(input int unsigned n);
    int unsigned start;
    int unsigned r;
    start = bytes_queued;
    while (bytes_queued - start < n) begin
      r = $urandom_range(99);
      if (r < 75) begin
        queue_frame(FrameBytes);
      end else if (r < 85) begin
        queue_byte(SyncFirst);
        queue_byte(8'($urandom));
      end else if (r < 92) begin
        queue_frame($urandom_range(FrameBytes - 1, 1));
      end else begin
        repeat ($urandom_range(4, 1)) queue_byte(8'($urandom));
      end
    end
  endtask

  task automatic wait_idle();
    while (bytes_taken != bytes_queued || words_due_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic check_word();
    word_t exp;
    if (words_due_q.size() == 0) begin
      flag_error($sformatf("unexpected word tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast));
    end else begin
      exp = words_due_q.pop_front();
      if (m_axis_tdata[15:0] != exp.value || m_axis_tdata[19:16] != exp.slot ||
          m_axis_tlast != exp.last)
        flag_error($sformatf("word got value=%h slot=%0d last=%b, exp value=%h slot=%0d last=%b",
                             m_axis_tdata[15:0], m_axis_tdata[19:16], m_axis_tlast,
                             exp.value, exp.slot, exp.last));
    end
  endtask

  // Byte driver: holds each byte until its transfer, idles at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        take_byte(s_axis_tdata);
        bytes_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (rx_bytes_q.size() != 0 && (steady || $urandom_range(99) >= IdlePct)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= rx_bytes_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Word monitor with random back-pressure and one long hold-off
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_word();
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && phase_num == 2 && m_axis_tvalid) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no transfer for %0d cycles", StallLimit);
        $display("FAIL sensor_frame_deframe_calibrate");
        $finish;
      end
    end
  end

  // Phases: registers change only with the block idle
  logic [7:0] directed [27] = '{
    // second 0x55 drops back to hunting, the 0xA5 after it is plain noise
    8'h55, 8'h55, 8'hA5,
    // wrong second sync byte
    8'h55, 8'h3C,
    // clean frame; sync codes inside the payload are data, tail bytes unused
    8'h55, 8'hA5,
    8'h00, 8'h00, 8'hFF, 8'hFF, 8'h55, 8'hA5, 8'hA5, 8'h55, 8'h00, 8'hFF,
    8'hFF, 8'h00, 8'h01, 8'h80, 8'hFE, 8'h7F, 8'h55, 8'h55, 8'hA5, 8'hA5
  };

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames, hand mode 0, offsets that force wrap-around
    phase_num = 1;
    write_reg(REG_HAND_MODE, 16'h0000);
    write_reg(REG_OFFSET_A, 16'hFFFF);
    write_reg(REG_OFFSET_B, 16'h0001);
    write_reg(REG_OFFSET_C, 16'h0000);
    write_reg(REG_OFFSET_D, 16'h8000);
    write_reg(REG_OFFSET_E, 16'h7FFF);
    end_writes();
    foreach (directed[i]) queue_byte(directed[i]);
    wait_idle();

    // Mirrored mode set through a value with the upper bits high; all offsets full
    phase_num = 2;
    write_reg(REG_HAND_MODE, 16'hFFFF);
    write_reg(REG_OFFSET_A, 16'hFFFF);
    write_reg(REG_OFFSET_B, 16'hFFFF);
    write_reg(REG_OFFSET_C, 16'hFFFF);
    write_reg(REG_OFFSET_D, 16'hFFFF);
    write_reg(REG_OFFSET_E, 16'hFFFF);
    write_reg(RegBeyondLo, 16'($urandom));
    end_writes();
    queue_random(90);
    wait_idle();

    // Hand mode 0 via a masked value, random offsets, no idling anywhere
    phase_num = 3;
    write_reg(REG_HAND_MODE, 16'hFFFE);
    for (int k = 0; k < NumOffsets; k++)
      write_reg(3'(REG_OFFSET_A + k), pick_offset());
    end_writes();
    steady = 1'b1;
    queue_random(100);
    wait_idle();
    steady = 1'b0;

    // Mirrored again with fresh offsets
    phase_num = 4;
    write_reg(REG_HAND_MODE, 16'h0001);
    for (int k = 0; k < NumOffsets; k++)
      write_reg(3'(REG_OFFSET_A + k), pick_offset());
    write_reg(RegBeyondHi, 16'($urandom));
    end_writes();
    queue_random(90);
    wait_idle();

    // Random mode and offsets for the rest of the stream
    phase_num = 5;
    write_reg(REG_HAND_MODE, 16'($urandom));
    for (int k = 0; k < NumOffsets; k++)
      write_reg(3'(REG_OFFSET_A + k), pick_offset());
    end_writes();
    if (bytes_queued < ItemTarget) queue_random(ItemTarget - bytes_queued);
    wait_idle();

    if (err_count == 0) begin
      $display("PASS sensor_frame_deframe_calibrate");
    end else begin
      $display("FAIL sensor_frame_deframe_calibrate");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sensor_frame_deframe_calibrate.f =====
hdl/sfdc_pkg.sv
hdl/sfdc_byte_cell.sv
hdl/sfdc_word_cell.sv
hdl/sensor_frame_deframe_calibrate.sv
test/tb_sensor_frame_deframe_calibrate.sv
